// File: src/i2cram_pkg.sv
// ----------------------------------------------------------------------------
// i2cram_pkg: shared types for the I2C register access master
// Phase codes, command codes, stream widths and the per-tick result record.
// ----------------------------------------------------------------------------
package i2cram_pkg;

  localparam int unsigned InTdataW  = 32;
  localparam int unsigned OutTdataW = 16;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_e;

  typedef enum logic [13:0] {
    PH_IDLE   = 14'b00000000000001,
    PH_START  = 14'b00000000000010,
    PH_ADDR_W = 14'b00000000000100,
    PH_ACK1   = 14'b00000000001000,
    PH_REG    = 14'b00000000010000,
    PH_ACK2   = 14'b00000000100000,
    PH_DATA   = 14'b00000001000000,
    PH_ACK3   = 14'b00000010000000,
    PH_RSTART = 14'b00000100000000,
    PH_ADDR_R = 14'b00001000000000,
    PH_ACK4   = 14'b00010000000000,
    PH_READ   = 14'b00100000000000,
    PH_MACK   = 14'b01000000000000,
    PH_STOP   = 14'b10000000000000
  } phase_e;

  typedef struct packed {
    logic [7:0] read_data;
    logic       nack_error;
    logic       done;
    logic       busy;
    logic       sda_release;
    logic       scl_level;
  } result_t;

endpackage

// File: src/i2c_register_access_master_unit.sv
// ----------------------------------------------------------------------------
// i2c_register_access_master_unit: I2C master for single-register transfers
// Result: the result of an item is registered and valid in the cycle after the item is taken.
// Throughput: one item per cycle; the output register is refilled in the same
// cycle it is drained, so the input stalls only while the output is stalled.
// Reset: asynchronous, active low; the sequencer returns to idle with all
// state cleared and the output register empty.
// ----------------------------------------------------------------------------
module i2c_register_access_master_unit
  import i2cram_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // cmd[1:0], dev_addr[8:2], reg_addr[16:9], wr_data[24:17], sda_in[25], zeros
  input  logic [InTdataW-1:0]  s_axis_tdata_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // scl_level[0], sda_release[1], busy_res[2], done_res[3], nack_error[4],
  // read_data[12:5], zeros
  output logic [OutTdataW-1:0] m_axis_tdata_o
);

  logic    accept;
  logic    out_valid_q, out_valid_d;
  result_t res;
  result_t out_res_q;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  i2cram_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (accept),
    .cmd_i      (s_axis_tdata_i[1:0]),
    .dev_addr_i (s_axis_tdata_i[8:2]),
    .reg_addr_i (s_axis_tdata_i[16:9]),
    .wr_data_i  (s_axis_tdata_i[24:17]),
    .sda_in_i   (s_axis_tdata_i[25]),
    .res_o      (res)
  );

  always_comb begin
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutTdataW - $bits(result_t)){1'b0}}, out_res_q};

endmodule

// File: src/i2cram_core.sv
// ----------------------------------------------------------------------------
// i2cram_core: bus sequencer of the I2C register access master
// Holds the transaction state and advances it by one sub-step of the current bus
// phase per enabled tick, producing the pin levels and status for that tick.
// ----------------------------------------------------------------------------
module i2cram_core
  import i2cram_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic [1:0] cmd_i,
  input  logic [6:0] dev_addr_i,
  input  logic [7:0] reg_addr_i,
  input  logic [7:0] wr_data_i,
  input  logic       sda_in_i,
  output result_t    res_o
);

  phase_e     phase_q, phase_d, cur_phase;
  logic [1:0] sub_q, sub_d;
  logic [3:0] bc_q, bc_d;
  logic [7:0] shift_q, shift_d;
  logic [6:0] dev_q, dev_d;
  logic [7:0] reg_q, reg_d;
  logic [7:0] data_q, data_d;
  logic       is_read_q, is_read_d;
  logic [7:0] rbyte_q, rbyte_d;
  logic       err_q, err_d;

  phase_e     send_next;
  phase_e     ack_next;
  logic [7:0] ack_byte;
  logic       scl, sda, busy, done, nerr;

  always_comb begin
    case (phase_q)
      PH_ADDR_W: send_next = PH_ACK1;
      PH_REG:    send_next = PH_ACK2;
      PH_DATA:   send_next = PH_ACK3;
      default:   send_next = PH_ACK4;
    endcase
  end

  always_comb begin
    ack_byte = '0;
    case (phase_q)
      PH_ACK1: begin
        ack_next = PH_REG;
        ack_byte = reg_q;
      end
      PH_ACK2: begin
        if (is_read_q) begin
          ack_next = PH_RSTART;
        end else begin
          ack_next = PH_DATA;
          ack_byte = data_q;
        end
      end
      PH_ACK3: ack_next = PH_STOP;
      default: ack_next = PH_READ;
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    sub_d     = sub_q;
    bc_d      = bc_q;
    shift_d   = shift_q;
    dev_d     = dev_q;
    reg_d     = reg_q;
    data_d    = data_q;
    is_read_d = is_read_q;
    rbyte_d   = rbyte_q;
    err_d     = err_q;
    scl       = 1'b1;
    sda       = 1'b1;
    busy      = 1'b1;
    done      = 1'b0;
    nerr      = 1'b0;

    if (phase_q == PH_IDLE && (cmd_i == CMD_WRITE || cmd_i == CMD_READ)) begin
      dev_d     = dev_addr_i;
      reg_d     = reg_addr_i;
      data_d    = wr_data_i;
      is_read_d = (cmd_i == CMD_READ);
      err_d     = 1'b0;
      phase_d   = PH_START;
      sub_d     = '0;
      bc_d      = '0;
      shift_d   = '0;
    end
    cur_phase = phase_d;

    case (cur_phase)
      PH_IDLE: begin
        busy = 1'b0;
      end
      PH_START: begin
        if (sub_d == 2'd0) begin
          sub_d = 2'd1;
        end else begin
          sda     = 1'b0;
          phase_d = PH_ADDR_W;
          sub_d   = '0;
          bc_d    = '0;
          shift_d = {dev_q, 1'b0};
        end
      end
      PH_ADDR_W, PH_REG, PH_DATA, PH_ADDR_R: begin
        sda = shift_d[7];
        if (sub_d == 2'd0) begin
          scl   = 1'b0;
          sub_d = 2'd1;
        end else begin
          sub_d   = '0;
          shift_d = {shift_d[6:0], 1'b0};
          bc_d    = bc_d + 4'd1;
          if (bc_d[3]) begin
            phase_d = send_next;
            bc_d    = '0;
            shift_d = '0;
          end
        end
      end
      PH_ACK1, PH_ACK2, PH_ACK3, PH_ACK4: begin
        if (sub_d == 2'd0) begin
          scl   = 1'b0;
          sub_d = 2'd1;
        end else begin
          sub_d = '0;
          bc_d  = '0;
          if (sda_in_i) begin
            err_d   = 1'b1;
            phase_d = PH_STOP;
            shift_d = '0;
          end else begin
            phase_d = ack_next;
            shift_d = ack_byte;
          end
        end
      end
      PH_RSTART: begin
        if (sub_d == 2'd0) begin
          scl   = 1'b0;
          sub_d = 2'd1;
        end else if (sub_d == 2'd1) begin
          sub_d = 2'd2;
        end else begin
          sda     = 1'b0;
          phase_d = PH_ADDR_R;
          sub_d   = '0;
          bc_d    = '0;
          shift_d = {dev_q, 1'b1};
        end
      end
      PH_READ: begin
        if (sub_d == 2'd0) begin
          scl   = 1'b0;
          sub_d = 2'd1;
        end else begin
          shift_d = {shift_d[6:0], sda_in_i};
          sub_d   = '0;
          bc_d    = bc_d + 4'd1;
          if (bc_d[3]) begin
            rbyte_d = shift_d;
            phase_d = PH_MACK;
            bc_d    = '0;
            shift_d = '0;
          end
        end
      end
      PH_MACK: begin
        if (sub_d == 2'd0) begin
          scl   = 1'b0;
          sub_d = 2'd1;
        end else begin
          phase_d = PH_STOP;
          sub_d   = '0;
          bc_d    = '0;
          shift_d = '0;
        end
      end
      PH_STOP: begin
        if (sub_d == 2'd0) begin
          scl   = 1'b0;
          sda   = 1'b0;
          sub_d = 2'd1;
        end else if (sub_d == 2'd1) begin
          sda   = 1'b0;
          sub_d = 2'd2;
        end else begin
          done    = 1'b1;
          nerr    = err_q;
          phase_d = PH_IDLE;
          sub_d   = '0;
          bc_d    = '0;
          shift_d = '0;
        end
      end
      default: begin
        busy    = 1'b0;
        phase_d = PH_IDLE;
        sub_d   = '0;
        bc_d    = '0;
        shift_d = '0;
      end
    endcase
  end

  assign res_o.scl_level   = scl;
  assign res_o.sda_release = sda;
  assign res_o.busy        = busy;
  assign res_o.done        = done;
  assign res_o.nack_error  = nerr;
  assign res_o.read_data   = rbyte_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      sub_q     <= '0;
      bc_q      <= '0;
      shift_q   <= '0;
      dev_q     <= '0;
      reg_q     <= '0;
      data_q    <= '0;
      is_read_q <= 1'b0;
      rbyte_q   <= '0;
      err_q     <= 1'b0;
    end else if (en_i) begin
      phase_q   <= phase_d;
      sub_q     <= sub_d;
      bc_q      <= bc_d;
      shift_q   <= shift_d;
      dev_q     <= dev_d;
      reg_q     <= reg_d;
      data_q    <= data_d;
      is_read_q <= is_read_d;
      rbyte_q   <= rbyte_d;
      err_q     <= err_d;
    end
  end

`ifndef SYNTHESIS
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> sub_q == 2'd0 && bc_q == 4'd0)
    else $error("idle phase with leftover bit or sub-phase count");

  a_bit_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !bc_q[3])
    else $error("bit count stored at eight or above");

  a_nack_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && res_o.nack_error |-> res_o.done && err_q)
    else $error("nack error reported outside the stop tick");

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && res_o.done |=> phase_q == PH_IDLE)
    else $error("sequencer not idle after stop completed");
`endif

endmodule

// File: verif/i2cram_bus_checker.sv
// ----------------------------------------------------------------------------
// i2cram_bus_checker: bus-level predictor and checker for the I2C master
// Watches both stream channels of the register access master, runs its own
// model of the START/byte/ack/STOP sequencer on every accepted tick item and
// compares each result item field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module i2cram_bus_checker
  import i2cram_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  input  logic                 s_tready_i,
  input  logic [InTdataW-1:0]  s_tdata_i,
  input  logic                 m_tvalid_i,
  input  logic                 m_tready_i,
  input  logic [OutTdataW-1:0] m_tdata_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  phase_e     bus_phase;
  logic [1:0] bit_step;
  logic [3:0] bit_cnt;
  logic [7:0] shifter;
  logic [6:0] dev_q;
  logic [7:0] regaddr_q;
  logic [7:0] wdata_q;
  logic       read_txn;
  logic [7:0] rx_byte;
  logic       nack_seen;

  result_t    line_q[$];
  int         result_idx;

  task automatic report_mismatch(input string what, input int got, input int want);
    if (fail_count_o < 100) begin
      $display("result %0d: %s is %0h, expected %0h", result_idx, what, got, want);
    end
    fail_count_o++;
  endtask

  task automatic goto_phase(input phase_e nxt, input logic [7:0] load);
    bus_phase = nxt;
    bit_step  = '0;
    bit_cnt   = '0;
    shifter   = load;
  endtask

  task automatic shift_out(inout result_t r, input phase_e nxt);
    r.sda_release = shifter[7];
    if (bit_step == 2'd0) begin
      r.scl_level = 1'b0;
      bit_step    = 2'd1;
    end else begin
      bit_step = 2'd0;
      shifter  = {shifter[6:0], 1'b0};
      bit_cnt  = bit_cnt + 4'd1;
      if (bit_cnt >= 4'd8) begin
        goto_phase(nxt, 8'h00);
      end
    end
  endtask

  // A released SDA in the ack slot is a NACK and sends the bus to STOP.
  task automatic ack_slot(inout result_t r, input logic sda_in, input phase_e nxt,
                          input logic [7:0] load);
    if (bit_step == 2'd0) begin
      r.scl_level = 1'b0;
      bit_step    = 2'd1;
    end else if (sda_in) begin
      nack_seen = 1'b1;
      goto_phase(PH_STOP, 8'h00);
    end else begin
      goto_phase(nxt, load);
    end
  endtask

  task automatic bus_tick(input logic [InTdataW-1:0] d, output result_t r);
    cmd_e cmd;
    logic sda_in;
    cmd    = cmd_e'(d[1:0]);
    sda_in = d[25];
    r             = '0;
    r.scl_level   = 1'b1;
    r.sda_release = 1'b1;
    r.busy        = 1'b1;
    if (bus_phase == PH_IDLE && (cmd == CMD_WRITE || cmd == CMD_READ)) begin
      dev_q     = d[8:2];
      regaddr_q = d[16:9];
      wdata_q   = d[24:17];
      read_txn  = (cmd == CMD_READ);
      nack_seen = 1'b0;
      goto_phase(PH_START, 8'h00);
    end
    case (bus_phase)
      PH_IDLE: begin
        r.busy = 1'b0;
      end
      PH_START: begin
        if (bit_step == 2'd0) begin
          bit_step = 2'd1;
        end else begin
          r.sda_release = 1'b0;
          goto_phase(PH_ADDR_W, {dev_q, 1'b0});
        end
      end
      PH_ADDR_W: shift_out(r, PH_ACK1);
      PH_ACK1:   ack_slot(r, sda_in, PH_REG, regaddr_q);
      PH_REG:    shift_out(r, PH_ACK2);
      PH_ACK2: begin
        if (read_txn) begin
          ack_slot(r, sda_in, PH_RSTART, 8'h00);
        end else begin
          ack_slot(r, sda_in, PH_DATA, wdata_q);
        end
      end
      PH_DATA:   shift_out(r, PH_ACK3);
      PH_ACK3:   ack_slot(r, sda_in, PH_STOP, 8'h00);
      PH_RSTART: begin
        if (bit_step == 2'd0) begin
          r.scl_level = 1'b0;
          bit_step    = 2'd1;
        end else if (bit_step == 2'd1) begin
          bit_step = 2'd2;
        end else begin
          r.sda_release = 1'b0;
          goto_phase(PH_ADDR_R, {dev_q, 1'b1});
        end
      end
      PH_ADDR_R: shift_out(r, PH_ACK4);
      PH_ACK4:   ack_slot(r, sda_in, PH_READ, 8'h00);
      PH_READ: begin
        if (bit_step == 2'd0) begin
          r.scl_level = 1'b0;
          bit_step    = 2'd1;
        end else begin
          shifter  = {shifter[6:0], sda_in};
          bit_step = 2'd0;
          bit_cnt  = bit_cnt + 4'd1;
          if (bit_cnt >= 4'd8) begin
            rx_byte = shifter;
            goto_phase(PH_MACK, 8'h00);
          end
        end
      end
      PH_MACK: begin
        if (bit_step == 2'd0) begin
          r.scl_level = 1'b0;
          bit_step    = 2'd1;
        end else begin
          goto_phase(PH_STOP, 8'h00);
        end
      end
      PH_STOP: begin
        if (bit_step == 2'd0) begin
          r.scl_level   = 1'b0;
          r.sda_release = 1'b0;
          bit_step      = 2'd1;
        end else if (bit_step == 2'd1) begin
          r.sda_release = 1'b0;
          bit_step      = 2'd2;
        end else begin
          r.done       = 1'b1;
          r.nack_error = nack_seen;
          goto_phase(PH_IDLE, 8'h00);
        end
      end
      default: begin
        r.busy = 1'b0;
        goto_phase(PH_IDLE, 8'h00);
      end
    endcase
    r.read_data = rx_byte;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    result_t got;
    if (!rst_ni) begin
      goto_phase(PH_IDLE, 8'h00);
      dev_q        = '0;
      regaddr_q    = '0;
      wdata_q      = '0;
      read_txn     = 1'b0;
      rx_byte      = '0;
      nack_seen    = 1'b0;
      result_idx   = 0;
      line_q.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got = result_t'(m_tdata_i[12:0]);
        if (line_q.size() == 0) begin
          report_mismatch("unexpected item", int'(got), 0);
        end else begin
          want = line_q.pop_front();
          if (got.scl_level !== want.scl_level)
            report_mismatch("scl_level", int'(got.scl_level), int'(want.scl_level));
          if (got.sda_release !== want.sda_release)
            report_mismatch("sda_release", int'(got.sda_release), int'(want.sda_release));
          if (got.busy !== want.busy)
            report_mismatch("busy", int'(got.busy), int'(want.busy));
          if (got.done !== want.done)
            report_mismatch("done", int'(got.done), int'(want.done));
          if (got.nack_error !== want.nack_error)
            report_mismatch("nack_error", int'(got.nack_error), int'(want.nack_error));
          if (got.read_data !== want.read_data)
            report_mismatch("read_data", int'(got.read_data), int'(want.read_data));
          if (m_tdata_i[OutTdataW-1:13] !== '0)
            report_mismatch("padding", int'(m_tdata_i[OutTdataW-1:13]), 0);
        end
        result_idx++;
      end
      if (s_tvalid_i && s_tready_i) begin
        bus_tick(s_tdata_i, want);
        line_q.push_back(want);
      end
      pending_o = line_q.size();
    end
  end

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the I2C register access master
// Feeds tick items that form write and read transfers with chosen acks,
// NACKs and read bytes, plus noisy traffic, with random gaps on both stream
// sides; the bus checker predicts every result item and counts mismatches.
// ----------------------------------------------------------------------------
module tb_top;
  import i2cram_pkg::*;

  localparam int WatchdogLimit = 500;
  localparam int RandomTicks   = 1400;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_valid;
  logic                 s_ready;
  logic [InTdataW-1:0]  s_data;
  logic                 m_valid;
  logic                 m_ready;
  logic [OutTdataW-1:0] m_data;
  int                   fail_count;
  int                   pending;
  int                   idle_cycles = 0;
  int                   ticks_sent;
  bit                   quiet;

  i2c_register_access_master_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  i2cram_bus_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_valid),
    .s_tready_i   (s_ready),
    .s_tdata_i    (s_data),
    .m_tvalid_i   (m_valid),
    .m_tready_i   (m_ready),
    .m_tdata_i    (m_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic int unsigned draw_gap();
    return quiet ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic logic [InTdataW-1:0] pack_tick(input cmd_e cmd, input logic [6:0] dev,
                                                    input logic [7:0] ra, input logic [7:0] wd,
                                                    input logic sda);
    return {6'b0, sda, wd, ra, dev, cmd};
  endfunction

  task automatic send_tick(input logic [InTdataW-1:0] d);
    int unsigned n;
    n = draw_gap();
    if (n > 0) begin
      s_valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= d;
    do @(posedge clk_i); while (!s_ready);
    ticks_sent++;
  endtask

  task automatic drain_results();
    s_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  task automatic idle_ticks(input int n);
    for (int i = 0; i < n; i++) begin
      send_tick(pack_tick($urandom_range(0, 1) ? CMD_RSVD : CMD_TICK,
                          7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
    end
  endtask

  // nack_slot 1..3 picks the ack slot the slave NACKs; a noisy transfer puts
  // random levels on SDA in every slot.
  task automatic run_transfer(input cmd_e op, input logic [6:0] dev, input logic [7:0] ra,
                              input logic [7:0] wd, input int nack_slot,
                              input logic [7:0] slave_byte, input bit noisy);
    int   ack_tick[3];
    int   len;
    cmd_e cmd;
    logic sda;
    ack_tick[0] = 19;
    ack_tick[1] = 37;
    ack_tick[2] = (op == CMD_READ) ? 58 : 55;
    len = (op == CMD_READ) ? 80 : 59;
    if (!noisy && nack_slot > 0) len = ack_tick[nack_slot-1] + 4;
    for (int i = 0; i < len; i++) begin
      cmd = (i == 0) ? op : cmd_e'($urandom_range(0, 3));
      sda = 1'($urandom_range(0, 1));
      if (!noisy) begin
        for (int k = 0; k < 3; k++) begin
          if (i == ack_tick[k]) sda = (k + 1 == nack_slot);
        end
        if (op == CMD_READ && i >= 60 && i <= 74 && i % 2 == 0) begin
          sda = slave_byte[7 - (i - 60) / 2];
        end
      end
      if (i == 0) begin
        send_tick(pack_tick(cmd, dev, ra, wd, sda));
      end else begin
        send_tick(pack_tick(cmd, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), sda));
      end
    end
  endtask

  initial begin
    m_ready = 1'b0;
    wait (rst_ni);
    forever begin
      int unsigned hold;
      @(posedge clk_i);
      if (m_valid && m_ready) hold = draw_gap();
      if (hold > 0) begin
        m_ready <= 1'b0;
        hold--;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("[i2c_register_access_master_unit] ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    cmd_e op;
    rst_ni      = 1'b0;
    s_valid     = 1'b0;
    s_data      = '0;
    ticks_sent  = 0;
    quiet       = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_tick(pack_tick(CMD_RSVD, 7'h7f, 8'hff, 8'hff, 1'b1));
    send_tick(pack_tick(CMD_TICK, 7'h00, 8'h00, 8'h00, 1'b0));
    run_transfer(CMD_WRITE, 7'h7f, 8'hff, 8'hff, 0, 8'h00, 1'b0);
    run_transfer(CMD_READ, 7'h00, 8'h00, 8'h00, 0, 8'hff, 1'b0);
    drain_results();
    run_transfer(CMD_READ, 7'h55, 8'haa, 8'h00, 0, 8'h00, 1'b0);
    for (int s = 1; s <= 3; s++) begin
      run_transfer(CMD_WRITE, 7'h2a, 8'h55, 8'ha5, s, 8'h00, 1'b0);
      run_transfer(CMD_READ, 7'h15, 8'h3c, 8'h5a, s, 8'h81, 1'b0);
    end
    drain_results();

    while (ticks_sent < RandomTicks) begin
      quiet = ($urandom_range(0, 3) == 0);
      op    = $urandom_range(0, 1) ? CMD_READ : CMD_WRITE;
      run_transfer(op, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)),
                   ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 3)) : 0,
                   8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
      idle_ticks(int'($urandom_range(0, 3)));
      if ($urandom_range(0, 7) == 0) drain_results();
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[i2c_register_access_master_unit] OK");
    end else begin
      $display("[i2c_register_access_master_unit] ERROR");
    end
    $finish;
  end

endmodule

// File: i2c_register_access_master_unit.f
src/i2cram_pkg.sv
src/i2cram_core.sv
src/i2c_register_access_master_unit.sv
verif/i2cram_bus_checker.sv
verif/tb_top.sv
